[design/positional_ordered_list_top_macros.svh]
// Assertion helpers for the positional ordered list.
// Clocked on clk_i and disabled while rst_ni is low.
`ifndef POSITIONAL_ORDERED_LIST_TOP_MACROS_SVH
`define POSITIONAL_ORDERED_LIST_TOP_MACROS_SVH

`ifndef SYNTH
`define POL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define POL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define POL_ASSERT(lbl, prop, msg)
`define POL_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[design/pol_pkg.sv]
`default_nettype none
package pol_pkg;

  typedef enum logic [2:0] {
    REQ_INS_FRONT = 3'd0,
    REQ_INS_BACK  = 3'd1,
    REQ_INS_AT    = 3'd2,
    REQ_DEL_FRONT = 3'd3,
    REQ_DEL_BACK  = 3'd4,
    REQ_DEL_AT    = 3'd5,
    REQ_READ_AT   = 3'd6
  } req_e;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_IGNORED = 2'd1,
    ST_REFUSED = 2'd2
  } status_e;

  localparam int unsigned PosW = 6;

  // Shift command broadcast to every cell
  typedef struct packed {
    logic            ins;
    logic            del;
    logic [PosW-1:0] idx;
  } cell_ctl_t;

endpackage
`default_nettype wire

[design/pol_cell.sv]
`default_nettype none
module pol_cell (
  input  wire                          clk_i,
  input  wire pol_pkg::cell_ctl_t      ctl_i,
  input  wire [pol_pkg::PosW-1:0]      my_idx_i,
  input  wire logic signed [31:0]      value_i,
  input  wire logic signed [31:0]      left_i,
  input  wire logic signed [31:0]      right_i,
  output logic signed [31:0]           data_o
);
  import pol_pkg::*;

  logic signed [31:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    if (ctl_i.ins) begin
      if (my_idx_i == ctl_i.idx) begin
        data_d = value_i;
      end else if (my_idx_i > ctl_i.idx) begin
        data_d = left_i;
      end
    end else if (ctl_i.del) begin
      // closing the gap: everything from the deleted slot pulls from the right
      if (my_idx_i >= ctl_i.idx) begin
        data_d = right_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule
`default_nettype wire

[design/pol_ctrl.sv]
`default_nettype none
`include "positional_ordered_list_top_macros.svh"
module pol_ctrl #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          accept_i,
  input  wire [2:0]                    req_type_i,
  input  wire [pol_pkg::PosW-1:0]      position_i,
  output pol_pkg::cell_ctl_t           ctl_o,
  output pol_pkg::status_e             status_o,
  output logic [pol_pkg::PosW-1:0]     count_o,
  output logic                         read_hit_o
);
  import pol_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  logic [CntW-1:0] count_q, count_d;
  logic [PosW:0]   pos_x, cnt_x;
  logic            full, empty;
  cell_ctl_t       ctl;
  status_e         status;
  logic            read_hit;

  assign pos_x = {1'b0, position_i};
  assign cnt_x = (PosW + 1)'(count_q);
  assign full  = (cnt_x == (PosW + 1)'(CAPACITY));
  assign empty = (count_q == '0);

  always_comb begin
    ctl      = '0;
    status   = ST_IGNORED;
    read_hit = 1'b0;
    unique case (req_type_i)
      REQ_INS_FRONT, REQ_INS_BACK: begin
        ctl.idx = (req_type_i == REQ_INS_FRONT) ? '0 : cnt_x[PosW-1:0];
        if (full) begin
          status = ST_REFUSED;
        end else begin
          ctl.ins = 1'b1;
          status  = ST_DONE;
        end
      end
      REQ_INS_AT: begin
        ctl.idx = position_i - PosW'(1);
        // position check comes before the full check
        if (pos_x == '0 || pos_x > cnt_x + (PosW + 1)'(1)) begin
          status = ST_IGNORED;
        end else if (full) begin
          status = ST_REFUSED;
        end else begin
          ctl.ins = 1'b1;
          status  = ST_DONE;
        end
      end
      REQ_DEL_FRONT, REQ_DEL_BACK: begin
        ctl.idx = (req_type_i == REQ_DEL_FRONT) ? '0 : cnt_x[PosW-1:0] - PosW'(1);
        if (!empty) begin
          ctl.del = 1'b1;
          status  = ST_DONE;
        end
      end
      REQ_DEL_AT: begin
        ctl.idx = position_i - PosW'(1);
        if (!empty && pos_x != '0 && pos_x <= cnt_x) begin
          ctl.del = 1'b1;
          status  = ST_DONE;
        end
      end
      REQ_READ_AT: begin
        if (pos_x != '0 && pos_x <= cnt_x) begin
          read_hit = 1'b1;
          status   = ST_DONE;
        end
      end
      default: begin
        status = ST_IGNORED;
      end
    endcase
    if (!accept_i) begin
      ctl.ins  = 1'b0;
      ctl.del  = 1'b0;
      read_hit = 1'b0;
    end
  end

  always_comb begin
    count_d = count_q;
    if (ctl.ins) begin
      count_d = count_q + CntW'(1);
    end else if (ctl.del) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign ctl_o      = ctl;
  assign status_o   = status;
  assign count_o    = PosW'(count_d);
  assign read_hit_o = read_hit;

  `POL_ASSERT(a_count_bound, cnt_x <= (PosW + 1)'(CAPACITY), "count above capacity")
  `POL_ASSERT(a_ins_del_excl, !(ctl.ins && ctl.del), "insert and delete together")
  `POL_ASSERT(a_ins_not_full, !ctl.ins || !full, "insert into full list")
  `POL_ASSERT_NEXT(a_refused_hold, accept_i && status == ST_REFUSED, $stable(count_q),
    "count moved on refused insert")

endmodule
`default_nettype wire

[design/positional_ordered_list_top.sv]
// Channel   Direction  Transfer when         Ports
// request   in         start_i && !busy_o    req_type_i, value_i, position_i
// result    out        done_o (one cycle)    status_o, count_o, read_value_o, read_valid_o
//
// One request per cycle: every cell compares its index with the request slot and
// shifts left, right or holds at the same edge, so busy_o never rises.
// The result is registered and appears in the cycle after the request transfer, for one cycle only.
// rst_ni clears the element count and the result strobe; cell contents stay stale.
// The receiver cannot stall; results are not held back.
`default_nettype none
`include "positional_ordered_list_top_macros.svh"
module positional_ordered_list_top #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          start_i,
  output logic                         busy_o,
  input  wire [2:0]                    req_type_i,
  input  wire logic signed [31:0]      value_i,
  input  wire [5:0]                    position_i,
  output logic                         done_o,
  output logic [1:0]                   status_o,
  output logic [5:0]                   count_o,
  output logic signed [31:0]           read_value_o,
  output logic                         read_valid_o
);
  import pol_pkg::*;

  localparam int unsigned IdxW = $clog2(CAPACITY);

  logic               accept;
  cell_ctl_t          ctl;
  status_e            status;
  logic [PosW-1:0]    count_next;
  logic               read_hit;
  logic signed [31:0] cell_data [CAPACITY];
  logic [PosW-1:0]    rd_slot;
  logic signed [31:0] rd_data;

  logic               done_q;
  logic [1:0]         status_q;
  logic [5:0]         count_q;
  logic signed [31:0] read_value_q;
  logic               read_valid_q;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  pol_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .req_type_i (req_type_i),
    .position_i (position_i),
    .ctl_o      (ctl),
    .status_o   (status),
    .count_o    (count_next),
    .read_hit_o (read_hit)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [31:0] left, right;
    if (i == 0) begin : g_first
      assign left = value_i;
    end else begin : g_mid
      assign left = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right = cell_data[i];
    end else begin : g_inner
      assign right = cell_data[i+1];
    end
    pol_cell u_cell (
      .clk_i    (clk_i),
      .ctl_i    (ctl),
      .my_idx_i (PosW'(i)),
      .value_i  (value_i),
      .left_i   (left),
      .right_i  (right),
      .data_o   (cell_data[i])
    );
  end

  // slot is only used on a hit, where it lies below the count
  assign rd_slot = position_i - PosW'(1);
  assign rd_data = cell_data[rd_slot[IdxW-1:0]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q       <= 1'b0;
      status_q     <= ST_DONE;
      count_q      <= '0;
      read_value_q <= '0;
      read_valid_q <= 1'b0;
    end else begin
      done_q       <= accept;
      read_valid_q <= read_hit;
      if (accept) begin
        status_q     <= status;
        count_q      <= count_next;
        read_value_q <= read_hit ? rd_data : '0;
      end
    end
  end

  assign done_o       = done_q;
  assign status_o     = status_q;
  assign count_o      = count_q;
  assign read_value_o = read_value_q;
  assign read_valid_o = read_valid_q;

  `POL_ASSERT(a_out_count, count_o <= 6'(CAPACITY), "reported count above capacity")
  `POL_ASSERT(a_read_valid, !read_valid_o || (done_o && status_o == ST_DONE),
    "read_valid without a completed read")
  `POL_ASSERT(a_refused_full, !(done_o && status_o == ST_REFUSED) || count_o == 6'(CAPACITY),
    "refused insert while not full")

endmodule
`default_nettype wire
